// File: sv/rcfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcfc_pkg;

  // Frame geometry
  localparam int unsigned PacketLenDef = 32;
  localparam int unsigned StoreDepth   = 23;
  localparam int unsigned ServoCount   = 22;
  localparam int unsigned StickCount   = 4;
  localparam int unsigned CountW       = 6;
  localparam int unsigned AddrW        = 5;

  // Header and checksum constants
  localparam logic [7:0] HdrControl = 8'hAA;
  localparam logic [7:0] HdrStick   = 8'hAB;
  localparam logic [7:0] SumInvert  = 8'hFF;

  // Output item kinds
  localparam logic KindStatus = 1'b0;
  localparam logic KindUpdate = 1'b1;

  typedef enum logic [1:0] {
    StatBad     = 2'd0,
    StatControl = 2'd1,
    StatStick   = 2'd2,
    StatUnknown = 2'd3
  } frame_status_e;

  typedef enum logic [1:0] {
    ModeNone    = 2'd0,
    ModeControl = 2'd1,
    ModeCheck   = 2'd2
  } mode_e;

  typedef enum logic {
    SeqCollect = 1'b0,
    SeqEmit    = 1'b1
  } seq_state_e;

endpackage

`default_nettype wire

// File: sv/radio_command_frame_checker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Radio command frame checker. Bytes of a PACKET_LEN-byte payload enter one per
// cycle on the slave stream (tuser set marks byte zero and restarts the frame).
// One 8-bit adder keeps the running checksum; the final byte is compared with
// the inverted sum. A good 0xAA frame then yields 22 servo updates, a good 0xAB
// frame 4 joystick updates, each followed by one status item; any other frame
// yields the status item alone. Results leave one per cycle while the master
// side accepts them, from a small sequencer that steps a counter over the byte
// store; the slave side is not ready while results are being sent.
module radio_command_frame_checker_unit #(
  parameter int unsigned PACKET_LEN = rcfc_pkg::PacketLenDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] first_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [1:0] frame_status, [6:2] value_index,
                                           // [14:7] value_byte, [16:15] current_mode
  output logic             m_axis_tuser,   // [0] item_kind
  output logic             m_axis_tlast    // run_last
);
  import rcfc_pkg::*;

  localparam logic [CountW-1:0] FinalIdx = CountW'(PACKET_LEN - 1);

  seq_state_e            state_q, state_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [7:0]            sum_q, sum_d;
  mode_e                 mode_q, mode_d;
  frame_status_e         status_q, status_d;
  logic [AddrW-1:0]      emit_q, emit_d;
  logic [AddrW-1:0]      total_q, total_d;
  logic [7:0]            store_q [StoreDepth];
  logic [7:0]            header_q;

  logic                  in_fire;
  logic [CountW-1:0]     idx;
  logic [7:0]            base_sum;
  logic                  is_final;
  logic                  wr_en;
  logic [AddrW-1:0]      rd_addr;
  logic                  last_item;
  logic [AddrW-1:0]      out_index;
  logic [7:0]            out_value;

  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // Restart the frame on a flagged byte
  assign idx      = s_axis_tuser ? '0 : count_q;
  assign base_sum = s_axis_tuser ? 8'h00 : sum_q;
  assign is_final = (idx >= FinalIdx);
  assign wr_en    = in_fire && !is_final && (idx < CountW'(StoreDepth));

  // Store frame bytes; the header is also held in its own register
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[idx[AddrW-1:0]] <= s_axis_tdata;
      if (idx == '0) begin
        header_q <= s_axis_tdata;
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SeqCollect;
      count_q  <= '0;
      sum_q    <= '0;
      mode_q   <= ModeNone;
      status_q <= StatBad;
      emit_q   <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      mode_q   <= mode_d;
      status_q <= status_d;
      emit_q   <= emit_d;
      total_q  <= total_d;
    end
  end

  // Next state: collect bytes, then step through the results
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sum_d    = sum_q;
    mode_d   = mode_q;
    status_d = status_q;
    emit_d   = emit_q;
    total_d  = total_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      SeqCollect: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (!is_final) begin
            sum_d   = base_sum + s_axis_tdata;
            count_d = idx + CountW'(1);
          end else begin
            count_d = '0;
            sum_d   = '0;
            emit_d  = '0;
            total_d = '0;
            state_d = SeqEmit;
            if ((base_sum ^ SumInvert) != s_axis_tdata) begin
              status_d = StatBad;
            end else if (header_q == HdrControl) begin
              status_d = StatControl;
              mode_d   = ModeControl;
              total_d  = AddrW'(ServoCount);
            end else if (header_q == HdrStick) begin
              status_d = StatStick;
              mode_d   = ModeCheck;
              total_d  = AddrW'(StickCount);
            end else begin
              status_d = StatUnknown;
            end
          end
        end
      end
      SeqEmit: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (last_item) begin
            state_d = SeqCollect;
          end else begin
            emit_d = emit_q + AddrW'(1);
          end
        end
      end
      default: begin
        state_d = SeqCollect;
      end
    endcase
  end

  // Form the result item
  assign last_item = (emit_q == total_q);
  assign rd_addr   = emit_q + AddrW'(1);
  assign out_value = last_item ? 8'h00 : store_q[rd_addr];

  always_comb begin
    if (last_item) begin
      out_index = '0;
    end else if (status_q == StatControl) begin
      out_index = emit_q;
    end else begin
      out_index = emit_q + AddrW'(ServoCount);
    end
  end

  assign m_axis_tdata = {7'd0, 2'(mode_q), out_value, out_index, 2'(status_q)};
  assign m_axis_tuser = last_item ? KindStatus : KindUpdate;
  assign m_axis_tlast = last_item;

endmodule

`default_nettype wire
